[hdl/u16u8_pkg.sv]
// Shared types and constants for the UTF-16 to UTF-8 encoder.
// Used by the interfaces, the encoder, the byte queue and the top level.
// Depends on nothing.
package u16u8_pkg;

  // Widths of the channel payloads.
  localparam int UNIT_W = 16;
  localparam int BYTE_W = 8;

  // Largest number of bytes one code unit can cause, and the counter width.
  localparam int MAX_BYTES = 4;
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);

  // Code unit boundaries.
  localparam logic [UNIT_W-1:0] ONE_BYTE_MAX = 16'h007F;
  localparam logic [UNIT_W-1:0] TWO_BYTE_MAX = 16'h07FF;
  localparam logic [UNIT_W-1:0] SUR_FIRST    = 16'hD800;
  localparam logic [UNIT_W-1:0] SUR_LAST     = 16'hDFFF;
  localparam logic [UNIT_W-1:0] NONCHAR_FE   = 16'hFFFE;
  localparam logic [UNIT_W-1:0] NONCHAR_FF   = 16'hFFFF;

  // Lead and continuation byte marks.
  localparam logic [BYTE_W-1:0] LEAD_FOUR = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD_THREE = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD_TWO  = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_MARK = 8'h80;

  // Replacement character U+FFFD as UTF-8.
  localparam logic [BYTE_W-1:0] REPL_B0 = 8'hEF;
  localparam logic [BYTE_W-1:0] REPL_B1 = 8'hBF;
  localparam logic [BYTE_W-1:0] REPL_B2 = 8'hBD;

  // Offset added to a surrogate pair's 20 payload bits.
  localparam logic [20:0] PAIR_BASE = 21'h10000;

  // Bytes caused by one code unit; entry 0 goes out first.
  typedef struct packed {
    logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
    logic [CNT_W-1:0]                 count;
  } enc_result_t;

endpackage

[hdl/u16u8_ifs.sv]
// Valid/ready channel interfaces for code units in and UTF-8 bytes out.
// Depends on u16u8_pkg.
interface u16u8_unit_if;
  logic                          valid;
  logic                          ready;
  logic [u16u8_pkg::UNIT_W-1:0]  code_unit;
  logic                          end_of_string;

  modport source (output valid, output code_unit, output end_of_string, input ready);
  modport sink   (input valid, input code_unit, input end_of_string, output ready);
endinterface

interface u16u8_byte_if;
  logic                          valid;
  logic                          ready;
  logic [u16u8_pkg::BYTE_W-1:0]  out_byte;
  logic                          last_byte;

  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

[hdl/u16u8_encoder.sv]
// Converts one registered code unit into up to four UTF-8 bytes and keeps the
// pending surrogate state between units.
// Depends on u16u8_pkg.
module u16u8_encoder (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  logic [u16u8_pkg::UNIT_W-1:0] code_unit,
  input  logic                         end_of_string,
  output u16u8_pkg::enc_result_t       result
);

  logic       pending;
  logic [9:0] held;
  logic       pending_next;
  logic [9:0] held_next;
  logic       is_sur;
  logic [20:0] cp;

  // Surrogate detection and pair code point.
  assign is_sur = (code_unit >= u16u8_pkg::SUR_FIRST) && (code_unit <= u16u8_pkg::SUR_LAST);
  assign cp     = u16u8_pkg::PAIR_BASE + {1'b0, held, code_unit[9:0]};

  // Byte generation and next surrogate state.
  always_comb begin
    result       = '0;
    pending_next = pending;
    held_next    = held;
    if (pending) begin
      pending_next = 1'b0;
      held_next    = '0;
      if (is_sur) begin
        result.bytes[0] = u16u8_pkg::LEAD_FOUR | {5'b0, cp[20:18]};
        result.bytes[1] = u16u8_pkg::CONT_MARK | {2'b0, cp[17:12]};
        result.bytes[2] = u16u8_pkg::CONT_MARK | {2'b0, cp[11:6]};
        result.bytes[3] = u16u8_pkg::CONT_MARK | {2'b0, cp[5:0]};
        result.count    = u16u8_pkg::CNT_W'(4);
      end else begin
        result.bytes[0] = u16u8_pkg::REPL_B0;
        result.bytes[1] = u16u8_pkg::REPL_B1;
        result.bytes[2] = u16u8_pkg::REPL_B2;
        result.count    = u16u8_pkg::CNT_W'(3);
      end
    end else if (code_unit <= u16u8_pkg::ONE_BYTE_MAX) begin
      result.bytes[0] = code_unit[7:0];
      result.count    = u16u8_pkg::CNT_W'(1);
    end else if (code_unit <= u16u8_pkg::TWO_BYTE_MAX) begin
      result.bytes[0] = u16u8_pkg::LEAD_TWO | {3'b0, code_unit[10:6]};
      result.bytes[1] = u16u8_pkg::CONT_MARK | {2'b0, code_unit[5:0]};
      result.count    = u16u8_pkg::CNT_W'(2);
    end else if (is_sur) begin
      if (end_of_string) begin
        result.bytes[0] = u16u8_pkg::REPL_B0;
        result.bytes[1] = u16u8_pkg::REPL_B1;
        result.bytes[2] = u16u8_pkg::REPL_B2;
        result.count    = u16u8_pkg::CNT_W'(3);
      end else begin
        pending_next = 1'b1;
        held_next    = code_unit[9:0];
      end
    end else if ((code_unit == u16u8_pkg::NONCHAR_FE) ||
                 (code_unit == u16u8_pkg::NONCHAR_FF)) begin
      result.count = '0;
    end else begin
      result.bytes[0] = u16u8_pkg::LEAD_THREE | {4'b0, code_unit[15:12]};
      result.bytes[1] = u16u8_pkg::CONT_MARK | {2'b0, code_unit[11:6]};
      result.bytes[2] = u16u8_pkg::CONT_MARK | {2'b0, code_unit[5:0]};
      result.count    = u16u8_pkg::CNT_W'(3);
    end
    // The end of a string always drops a held surrogate.
    if (end_of_string) begin
      pending_next = 1'b0;
      held_next    = '0;
    end
  end

  // Surrogate state advances only when the unit moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
      held    <= '0;
    end else if (advance) begin
      pending <= pending_next;
      held    <= held_next;
    end
  end

  // A unit that ends the string leaves nothing held.
  a_eos_clears: assert property (@(posedge clk) disable iff (rst)
    advance && end_of_string |=> !pending && (held == '0))
    else $error("surrogate still held after end of string");

  // A pending surrogate is always resolved by the next unit.
  a_pair_resolves: assert property (@(posedge clk) disable iff (rst)
    advance && pending |-> (result.count == u16u8_pkg::CNT_W'(4)) ||
                           (result.count == u16u8_pkg::CNT_W'(3)))
    else $error("pending surrogate not resolved");

endmodule

[hdl/u16u8_byte_queue.sv]
// Holds the bytes of one converted code unit and hands them out one per cycle while byte_out is ready.
// Depends on u16u8_pkg and u16u8_byte_if.
module u16u8_byte_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  u16u8_pkg::enc_result_t result,
  output logic                   can_load,
  u16u8_byte_if.source           byte_out
);

  logic [u16u8_pkg::MAX_BYTES-1:0][u16u8_pkg::BYTE_W-1:0] bytes;
  logic [u16u8_pkg::CNT_W-1:0]                            cnt;
  logic                                                   pop;

  // A new group may enter when the queue is empty or its last byte leaves now.
  assign pop      = (cnt != '0) && byte_out.ready;
  assign can_load = (cnt == '0) || ((cnt == u16u8_pkg::CNT_W'(1)) && byte_out.ready);

  assign byte_out.valid     = (cnt != '0);
  assign byte_out.out_byte  = bytes[0];
  assign byte_out.last_byte = (cnt == u16u8_pkg::CNT_W'(1));

  // Byte count.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= result.count;
    end else if (pop) begin
      cnt <= cnt - u16u8_pkg::CNT_W'(1);
    end
  end

  // Byte storage; the head byte shifts out on each pop.
  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= result.bytes;
    end else if (pop) begin
      bytes <= {u16u8_pkg::BYTE_W'(0), bytes[u16u8_pkg::MAX_BYTES-1:1]};
    end
  end

  // The count never exceeds the longest sequence.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= u16u8_pkg::CNT_W'(u16u8_pkg::MAX_BYTES))
    else $error("byte count out of range");

  // A pop in the middle of a group removes exactly one byte.
  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    pop && (cnt > u16u8_pkg::CNT_W'(1)) |=> cnt == $past(cnt) - u16u8_pkg::CNT_W'(1))
    else $error("byte count did not step down by one");

endmodule

[hdl/utf16_to_utf8_encoder.sv]
// Top level of the UTF-16 to UTF-8 encoder: input register, encoder, byte queue.
// Depends on u16u8_pkg, u16u8_ifs, u16u8_encoder and u16u8_byte_queue.
//
// Usage:
//   unit_in takes one UTF-16 code unit per item, with end_of_string set on
//   the last unit of a string. byte_out gives UTF-8 bytes one per item, with
//   last_byte set on the final byte caused by a code unit.
//   Order: a unit taken on unit_in is first held in the input register; the
//   encoder converts it combinationally, and it is loaded into the byte queue
//   once the queue has room, from where its first byte is offered on byte_out.
//   Throughput: one unit per cycle for ASCII text while the receiver keeps
//   ready high; a unit that gives several bytes holds the byte queue until its
//   last byte leaves, and no new unit is loaded before then; units that give
//   no byte (a held first surrogate, U+FFFE, U+FFFF) load an empty group.
//   While the receiver holds ready low, the offered byte stays put, the queue
//   stops, and unit_in drops ready once the input register is full.
//   Reset (synchronous, active high) empties both stages and forgets any
//   held surrogate.
module utf16_to_utf8_encoder (
  input  logic         clk,
  input  logic         rst,
  u16u8_unit_if.sink   unit_in,
  u16u8_byte_if.source byte_out
);

  logic                         a_valid;
  logic [u16u8_pkg::UNIT_W-1:0] a_unit;
  logic                         a_eos;
  logic                         can_load;
  logic                         a_move;
  u16u8_pkg::enc_result_t       result;

  // The registered unit moves into the byte queue when it has room.
  assign a_move        = a_valid && can_load;
  assign unit_in.ready = !a_valid || can_load;

  // Input register: valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (unit_in.valid && unit_in.ready) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  // Input register: payload.
  always_ff @(posedge clk) begin
    if (unit_in.valid && unit_in.ready) begin
      a_unit <= unit_in.code_unit;
      a_eos  <= unit_in.end_of_string;
    end
  end

  u16u8_encoder u_encoder (
    .clk           (clk),
    .rst           (rst),
    .advance       (a_move),
    .code_unit     (a_unit),
    .end_of_string (a_eos),
    .result        (result)
  );

  u16u8_byte_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .load     (a_move),
    .result   (result),
    .can_load (can_load),
    .byte_out (byte_out)
  );

  // A four-byte group starts with a four-byte lead.
  a_four_lead: assert property (@(posedge clk) disable iff (rst)
    a_move && (result.count == u16u8_pkg::CNT_W'(4)) |=>
      byte_out.valid && (byte_out.out_byte[7:3] == 5'b11110) && !byte_out.last_byte)
    else $error("four-byte group without proper lead byte");

  // A held unit that cannot move keeps the input side closed.
  a_hold_blocks: assert property (@(posedge clk) disable iff (rst)
    a_valid && !can_load |-> !unit_in.ready)
    else $error("input accepted while the register is blocked");

endmodule

[bench/u16u8_byte_check.sv]
// Monitor and predictor for the UTF-16 to UTF-8 encoder's two channels.
// Predicts the UTF-8 bytes for each accepted code unit and compares the byte stream.
// Depends on u16u8_pkg.
module u16u8_byte_check (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         unit_valid,
  input  logic                         unit_ready,
  input  logic [u16u8_pkg::UNIT_W-1:0] code_unit,
  input  logic                         end_of_string,
  input  logic                         byte_valid,
  input  logic                         byte_ready,
  input  logic [u16u8_pkg::BYTE_W-1:0] out_byte,
  input  logic                         last_byte,
  output int                           mismatches,
  output int                           bytes_waiting
);

  // One predicted byte on the output channel.
  typedef struct packed {
    logic [u16u8_pkg::BYTE_W-1:0] value;
    logic                         last;
  } utf8_byte_t;

  utf8_byte_t expected_bytes[$];

  // Predictor state: a held first surrogate and its payload bits.
  logic       pair_open;
  logic [9:0] held_bits;
  int         unit_bytes;

  initial begin
    mismatches    = 0;
    bytes_waiting = 0;
    pair_open     = 1'b0;
    held_bits     = '0;
  end

  // Print one line per mismatch and count it.
  task report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  function void add_byte(input logic [u16u8_pkg::BYTE_W-1:0] value);
    utf8_byte_t b;
    b.value = value;
    b.last  = 1'b0;
    expected_bytes.insert(expected_bytes.size(), b);
    unit_bytes++;
  endfunction

  // U+FFFD in UTF-8.
  function void add_replacement();
    add_byte(u16u8_pkg::REPL_B0);
    add_byte(u16u8_pkg::REPL_B1);
    add_byte(u16u8_pkg::REPL_B2);
  endfunction

  // Queue the bytes that one code unit causes and advance the surrogate state.
  function automatic void encode_unit(input logic [u16u8_pkg::UNIT_W-1:0] cu,
                                      input logic eos);
    logic        is_sur;
    logic [20:0] cp;
    is_sur     = (cu >= u16u8_pkg::SUR_FIRST) && (cu <= u16u8_pkg::SUR_LAST);
    unit_bytes = 0;
    if (pair_open) begin
      // Any surrogate completes the pair; anything else breaks it and is consumed.
      pair_open = 1'b0;
      if (is_sur) begin
        cp = u16u8_pkg::PAIR_BASE + {1'b0, held_bits, cu[9:0]};
        add_byte(u16u8_pkg::LEAD_FOUR | 8'(cp[20:18]));
        add_byte(u16u8_pkg::CONT_MARK | 8'(cp[17:12]));
        add_byte(u16u8_pkg::CONT_MARK | 8'(cp[11:6]));
        add_byte(u16u8_pkg::CONT_MARK | 8'(cp[5:0]));
      end else begin
        add_replacement();
      end
      held_bits = '0;
    end else if (cu <= u16u8_pkg::ONE_BYTE_MAX) begin
      add_byte(cu[7:0]);
    end else if (cu <= u16u8_pkg::TWO_BYTE_MAX) begin
      add_byte(u16u8_pkg::LEAD_TWO | 8'(cu[10:6]));
      add_byte(u16u8_pkg::CONT_MARK | 8'(cu[5:0]));
    end else if (is_sur) begin
      // A lone surrogate at the end of a string cannot be paired.
      if (eos) begin
        add_replacement();
      end else begin
        pair_open = 1'b1;
        held_bits = cu[9:0];
      end
    end else if (cu == u16u8_pkg::NONCHAR_FE || cu == u16u8_pkg::NONCHAR_FF) begin
      // Noncharacters are dropped without output.
    end else begin
      add_byte(u16u8_pkg::LEAD_THREE | 8'(cu[15:12]));
      add_byte(u16u8_pkg::CONT_MARK | 8'(cu[11:6]));
      add_byte(u16u8_pkg::CONT_MARK | 8'(cu[5:0]));
    end
    if (eos) begin
      pair_open = 1'b0;
      held_bits = '0;
    end
    if (unit_bytes > 0) begin
      expected_bytes[expected_bytes.size() - 1].last = 1'b1;
    end
  endfunction

  // Compare accepted bytes first, then predict for an accepted unit; a unit
  // cannot produce a byte at the edge that accepts it.
  always @(posedge clk) begin
    utf8_byte_t want;
    if (rst) begin
      pair_open = 1'b0;
      held_bits = '0;
      expected_bytes.delete();
    end else begin
      if (byte_valid && byte_ready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %h", out_byte));
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want.value) begin
            report_mismatch($sformatf("out_byte %h, wanted %h", out_byte, want.value));
          end
          if (last_byte !== want.last) begin
            report_mismatch($sformatf("last_byte %b, wanted %b on byte %h",
                                      last_byte, want.last, want.value));
          end
        end
      end
      if (unit_valid && unit_ready) begin
        encode_unit(code_unit, end_of_string);
      end
    end
    bytes_waiting = expected_bytes.size();
  end

endmodule

[bench/tb_utf16_to_utf8_encoder.sv]
// Testbench top for the UTF-16 to UTF-8 encoder: clock, reset, stimulus and verdict.
// Depends on u16u8_pkg, u16u8_ifs, utf16_to_utf8_encoder and u16u8_byte_check.
module tb_utf16_to_utf8_encoder;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_UNITS = 430;

  logic clk;
  logic rst;
  bit   calm;
  int   mismatches;
  int   bytes_waiting;
  int   cycle_count = 0;
  int   stall_left  = 0;

  u16u8_unit_if unit_ch ();
  u16u8_byte_if byte_ch ();

  utf16_to_utf8_encoder u_dut (
    .clk      (clk),
    .rst      (rst),
    .unit_in  (unit_ch),
    .byte_out (byte_ch)
  );

  u16u8_byte_check u_byte_check (
    .clk           (clk),
    .rst           (rst),
    .unit_valid    (unit_ch.valid),
    .unit_ready    (unit_ch.ready),
    .code_unit     (unit_ch.code_unit),
    .end_of_string (unit_ch.end_of_string),
    .byte_valid    (byte_ch.valid),
    .byte_ready    (byte_ch.ready),
    .out_byte      (byte_ch.out_byte),
    .last_byte     (byte_ch.last_byte),
    .mismatches    (mismatches),
    .bytes_waiting (bytes_waiting)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then long, none in calm stretches.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end else begin
      return $urandom_range(8, 40);
    end
  endfunction

  // Receiver: ready drops for random stretches.
  initial begin
    byte_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        byte_ch.ready <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        byte_ch.ready <= 1'b0;
        stall_left = pick_gap();
      end else begin
        byte_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one code unit after an optional gap and hold it until accepted.
  // Entered and left at a falling edge.
  task automatic send_unit(input logic [u16u8_pkg::UNIT_W-1:0] unit, input logic eos);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      unit_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    unit_ch.valid         <= 1'b1;
    unit_ch.code_unit     <= unit;
    unit_ch.end_of_string <= eos;
    do @(posedge clk); while (!unit_ch.ready);
    @(negedge clk);
  endtask

  // Hold off the sender until every predicted byte has come out.
  task automatic drain();
    unit_ch.valid <= 1'b0;
    @(negedge clk);
    while (bytes_waiting != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // A code unit outside the surrogate range.
  function automatic logic [u16u8_pkg::UNIT_W-1:0] plain_unit();
    logic [u16u8_pkg::UNIT_W-1:0] u;
    u = 16'($urandom);
    if (u >= u16u8_pkg::SUR_FIRST && u <= u16u8_pkg::SUR_LAST) begin
      u = u ^ 16'h2000;
    end
    return u;
  endfunction

  // One of the two noncharacters, chosen at random.
  function automatic logic [u16u8_pkg::UNIT_W-1:0] nonchar_unit();
    return $urandom_range(0, 1) ? u16u8_pkg::NONCHAR_FE : u16u8_pkg::NONCHAR_FF;
  endfunction

  initial begin
    int counted;
    int rounds;
    int kind;
    logic eos;
    rst                   = 1'b1;
    calm                  = 1'b0;
    unit_ch.valid         = 1'b0;
    unit_ch.code_unit     = '0;
    unit_ch.end_of_string = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Directed: range edges, noncharacters, pairs and broken pairs.
    send_unit(16'h0000, 1'b0);
    send_unit(u16u8_pkg::ONE_BYTE_MAX, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(u16u8_pkg::TWO_BYTE_MAX, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hD7FF, 1'b0);
    send_unit(16'hE000, 1'b0);
    send_unit(16'hFFFD, 1'b0);
    send_unit(u16u8_pkg::NONCHAR_FE, 1'b0);
    send_unit(u16u8_pkg::NONCHAR_FF, 1'b1);
    send_unit(u16u8_pkg::SUR_FIRST, 1'b0);
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDBFF, 1'b0);
    send_unit(u16u8_pkg::SUR_LAST, 1'b0);
    // Reversed kinds still pair up.
    send_unit(16'hDC00, 1'b0);
    send_unit(u16u8_pkg::SUR_FIRST, 1'b0);
    // Broken pairs, including a consumed noncharacter.
    send_unit(16'hD83D, 1'b0);
    send_unit(16'h0041, 1'b0);
    send_unit(u16u8_pkg::SUR_FIRST, 1'b0);
    send_unit(u16u8_pkg::NONCHAR_FE, 1'b0);
    send_unit(16'hDABC, 1'b0);
    send_unit(u16u8_pkg::NONCHAR_FF, 1'b1);
    // Lone surrogate at end of string, then a pair that ends the string.
    send_unit(16'hDABC, 1'b1);
    send_unit(u16u8_pkg::SUR_FIRST, 1'b0);
    send_unit(u16u8_pkg::SUR_LAST, 1'b1);
    drain();

    // Random: mostly valid text and well-formed pairs, some broken sequences.
    counted = 0;
    rounds  = 0;
    while (counted < RANDOM_UNITS) begin
      if (rounds % 40 == 0) begin
        calm = ($urandom_range(0, 3) == 0);
      end
      rounds++;
      kind = $urandom_range(0, 99);
      eos  = ($urandom_range(0, 7) == 0);
      if (kind < 20) begin
        send_unit(16'($urandom_range(0, 16'h7F)), eos);
        counted++;
      end else if (kind < 35) begin
        send_unit(16'($urandom_range(16'h80, 16'h7FF)), eos);
        counted++;
      end else if (kind < 50) begin
        send_unit(16'($urandom), eos);
        counted++;
      end else if (kind < 54) begin
        send_unit(nonchar_unit(), eos);
      end else if (kind < 80) begin
        send_unit(16'($urandom_range(16'hD800, 16'hDBFF)), 1'b0);
        send_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), eos);
        counted += 2;
      end else if (kind < 90) begin
        send_unit(16'($urandom_range(u16u8_pkg::SUR_FIRST, u16u8_pkg::SUR_LAST)), eos);
        counted++;
      end else begin
        send_unit(16'($urandom_range(u16u8_pkg::SUR_FIRST, u16u8_pkg::SUR_LAST)), 1'b0);
        send_unit($urandom_range(0, 4) == 0 ? nonchar_unit() : plain_unit(), eos);
        counted += 2;
      end
      if ($urandom_range(0, 59) == 0) begin
        drain();
      end
    end

    // Let the last bytes out, then give the verdict.
    drain();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && bytes_waiting == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
